>>> rtl/cob_pkg.sv
// Shared types and constants for the cursor overlay alpha blend block.
package cob_pkg;

	localparam int STORE_DEPTH            = 4096;
	localparam int STORE_AW               = $clog2(STORE_DEPTH);
	localparam int CURSOR_MAX_SIDE_DEF    = 64;
	localparam int FRAME_MAX_SIDE_DEF     = 8192;
	localparam logic [7:0] FULL_ALPHA     = 8'd255;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 14;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OVERLAY_ENABLE = 3'd0,
		REG_CURSOR_X       = 3'd1,
		REG_CURSOR_Y       = 3'd2,
		REG_CURSOR_WIDTH   = 3'd3,
		REG_CURSOR_HEIGHT  = 3'd4,
		REG_TEXEL_COUNT    = 3'd5,
		REG_FRAME_WIDTH    = 3'd6,
		REG_FRAME_HEIGHT   = 3'd7
	} cfg_reg_t;

	typedef enum logic {
		KIND_LOAD  = 1'b0,
		KIND_PIXEL = 1'b1
	} kind_t;

	typedef struct packed {
		logic [7:0] fourth;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pix_t;

	// Result of the rectangle and frame test for one pixel
	typedef struct packed {
		logic       in_rect;
		logic [6:0] dx;
		logic [6:0] dy;
	} loc_t;

	// Beat handed to the blend stages
	typedef struct packed {
		logic        valid;
		logic        hit;
		logic [31:0] texel;
		pix_t        pixel;
	} blend_in_t;

endpackage

>>> rtl/cob_locate.sv
// Cursor rectangle and frame clip test for an incoming pixel.
module cob_locate import cob_pkg::*; (
	input  logic               enable,
	input  logic signed [13:0] cursor_x,
	input  logic signed [13:0] cursor_y,
	input  logic [6:0]         cursor_width,
	input  logic [6:0]         cursor_height,
	input  logic [13:0]        frame_width,
	input  logic [13:0]        frame_height,
	input  logic [12:0]        pixel_x,
	input  logic [12:0]        pixel_y,
	output loc_t               loc
);

	logic signed [14:0] dx;
	logic signed [14:0] dy;
	logic               in_x;
	logic               in_y;
	logic               in_frame;

	always_comb begin
		dx = $signed({2'b00, pixel_x}) - $signed({cursor_x[13], cursor_x});
		dy = $signed({2'b00, pixel_y}) - $signed({cursor_y[13], cursor_y});
		in_x = !dx[14] && (dx[13:0] < {7'd0, cursor_width});
		in_y = !dy[14] && (dy[13:0] < {7'd0, cursor_height});
		in_frame = ({1'b0, pixel_x} < frame_width) && ({1'b0, pixel_y} < frame_height);
		loc.in_rect = enable && in_x && in_y && in_frame;
		loc.dx      = dx[6:0];
		loc.dy      = dy[6:0];
	end

endmodule

>>> rtl/cob_sprite_mem.sv
// Sprite texel store: one write port, one registered read port.
module cob_sprite_mem import cob_pkg::*; (
	input  logic                clk,
	input  logic                we,
	input  logic [STORE_AW-1:0] waddr,
	input  logic [31:0]         wdata,
	input  logic                re,
	input  logic [STORE_AW-1:0] raddr,
	output logic [31:0]         rdata
);

	logic [31:0] mem [STORE_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/cob_blend.sv
// Alpha blend: product stage, then exact divide by 255.
module cob_blend import cob_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      advance,
	input  blend_in_t bin,
	output logic      valid,
	output pix_t      result,
	output logic      covered
);

	logic [31:0] src;
	logic [7:0]  alpha;
	logic [7:0]  inv_alpha;
	logic [15:0] prod_b;
	logic [15:0] prod_g;
	logic [15:0] prod_r;

	logic        valid_s3;
	logic        covered_s3;
	logic [15:0] sum_b_s3;
	logic [15:0] sum_g_s3;
	logic [15:0] sum_r_s3;
	logic [7:0]  fourth_s3;

	function automatic logic [15:0] mix_sum(input logic [7:0] s, input logic [7:0] d,
		input logic [7:0] a, input logic [7:0] na);
		mix_sum = ({8'd0, s} * {8'd0, a}) + ({8'd0, d} * {8'd0, na});
	endfunction

	// x / 255 for x up to 65025 (the largest blend sum), by reciprocal with correction
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] t;
		t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
		div255 = t[15:8];
	endfunction

	always_comb begin
		// a miss blends a zero texel, which keeps the pixel
		src       = bin.hit ? bin.texel : 32'd0;
		alpha     = src[31:24];
		inv_alpha = FULL_ALPHA - alpha;
		prod_b    = mix_sum(src[7:0],   bin.pixel.blue,  alpha, inv_alpha);
		prod_g    = mix_sum(src[15:8],  bin.pixel.green, alpha, inv_alpha);
		prod_r    = mix_sum(src[23:16], bin.pixel.red,   alpha, inv_alpha);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (advance) begin
			valid_s3 <= bin.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			covered_s3 <= (alpha != 8'd0);
			sum_b_s3   <= prod_b;
			sum_g_s3   <= prod_g;
			sum_r_s3   <= prod_r;
			fourth_s3  <= bin.pixel.fourth;
		end
	end

	always_comb begin
		valid         = valid_s3;
		covered       = covered_s3;
		result.blue   = div255(sum_b_s3);
		result.green  = div255(sum_g_s3);
		result.red    = div255(sum_r_s3);
		result.fourth = fourth_s3;
	end

endmodule

>>> rtl/cursor_overlay_alpha_blend_top.sv
// Top level of the cursor overlay alpha blend block.
//
// Overlays a colour cursor sprite on a stream of BGRA pixels. The block takes
// one beat per clock on s_* while the output is not stalled, and gives one
// result beat per pixel beat on m_*; load beats (tuser 0) write a texel into
// the 4096-entry sprite store and give no result. The four stages are: input
// register (rectangle and frame test done on the way in), texel address
// multiply and store read, blend products, divide by 255 into the output
// register. A stall on m_tready holds every stage at once, so s_tready follows
// the output register being free or drained.
// The sprite store has no clearing pass: read only entries that were loaded.
// Configuration registers are written through cfg_we/cfg_index/cfg_wdata and
// are to be changed only while no pixel is in flight.
module cursor_overlay_alpha_blend_top import cob_pkg::*; #(
	parameter int CURSOR_MAX_SIDE = CURSOR_MAX_SIDE_DEF,
	parameter int FRAME_MAX_SIDE  = FRAME_MAX_SIDE_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// texel_index[11:0], pixel_x[24:12], pixel_y[37:25], in_blue[45:38],
	// in_green[53:46], in_red[61:54], in_fourth[69:62], zero pad [71:70]
	input  logic [71:0]           s_tdata,
	// kind[0]
	input  logic [0:0]            s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// out_blue[7:0], out_green[15:8], out_red[23:16], out_fourth[31:24]
	output logic [31:0]           m_tdata,
	// covered[0]
	output logic [0:0]            m_tuser,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam logic [8:0]  CursorMax = 9'(CURSOR_MAX_SIDE);
	localparam logic [14:0] FrameMax  = 15'(FRAME_MAX_SIDE);

	// Configuration registers; sides are saturated as they are written
	logic               overlay_enable_q;
	logic signed [13:0] cursor_x_q;
	logic signed [13:0] cursor_y_q;
	logic [6:0]         cursor_width_q;
	logic [6:0]         cursor_height_q;
	logic [12:0]        texel_count_q;
	logic [13:0]        frame_width_q;
	logic [13:0]        frame_height_q;

	logic        advance;
	logic        in_beat;
	kind_t       in_kind;
	logic [11:0] in_texel_index;
	logic [12:0] in_pixel_x;
	logic [12:0] in_pixel_y;
	pix_t        in_pix;
	loc_t        in_loc;

	// Stage 1: input register
	logic        valid_s1;
	kind_t       kind_s1;
	logic [11:0] texel_index_s1;
	pix_t        pix_s1;
	loc_t        loc_s1;

	logic [14:0] ti_s1;
	logic        hit_s1;
	logic        load_we;

	// Stage 2: store read data lines up with these
	logic        valid_s2;
	logic        hit_s2;
	pix_t        pix_s2;
	logic [31:0] texel_s2;

	blend_in_t   bin;
	logic        blend_valid;
	pix_t        blend_pix;
	logic        blend_covered;

	pix_t        out_pix_q;
	logic        covered_q;

	function automatic logic [6:0] sat_side(input logic [6:0] v);
		sat_side = ({2'b00, v} > CursorMax) ? CursorMax[6:0] : v;
	endfunction

	function automatic logic [13:0] sat_frame(input logic [13:0] v);
		sat_frame = ({1'b0, v} > FrameMax) ? FrameMax[13:0] : v;
	endfunction

	// ---- configuration port ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			overlay_enable_q <= 1'b0;
			cursor_x_q       <= '0;
			cursor_y_q       <= '0;
			cursor_width_q   <= '0;
			cursor_height_q  <= '0;
			texel_count_q    <= '0;
			frame_width_q    <= '0;
			frame_height_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_OVERLAY_ENABLE: overlay_enable_q <= cfg_wdata[0];
				REG_CURSOR_X:       cursor_x_q       <= $signed(cfg_wdata);
				REG_CURSOR_Y:       cursor_y_q       <= $signed(cfg_wdata);
				REG_CURSOR_WIDTH:   cursor_width_q   <= sat_side(cfg_wdata[6:0]);
				REG_CURSOR_HEIGHT:  cursor_height_q  <= sat_side(cfg_wdata[6:0]);
				REG_TEXEL_COUNT:    texel_count_q    <= cfg_wdata[12:0];
				REG_FRAME_WIDTH:    frame_width_q    <= sat_frame(cfg_wdata);
				REG_FRAME_HEIGHT:   frame_height_q   <= sat_frame(cfg_wdata);
				default:            overlay_enable_q <= overlay_enable_q;
			endcase
		end
	end

	// ---- flow control: every stage moves together unless the output is stuck ----
	assign advance  = !m_tvalid || m_tready;
	assign s_tready = advance;
	assign in_beat  = s_tvalid && advance;

	// Unpack the input beat
	always_comb begin
		in_kind        = kind_t'(s_tuser[0]);
		in_texel_index = s_tdata[11:0];
		in_pixel_x     = s_tdata[24:12];
		in_pixel_y     = s_tdata[37:25];
		in_pix.blue    = s_tdata[45:38];
		in_pix.green   = s_tdata[53:46];
		in_pix.red     = s_tdata[61:54];
		in_pix.fourth  = s_tdata[69:62];
	end

	// Rectangle and frame test on the way into stage 1
	cob_locate u_locate (
		.enable        (overlay_enable_q),
		.cursor_x      (cursor_x_q),
		.cursor_y      (cursor_y_q),
		.cursor_width  (cursor_width_q),
		.cursor_height (cursor_height_q),
		.frame_width   (frame_width_q),
		.frame_height  (frame_height_q),
		.pixel_x       (in_pixel_x),
		.pixel_y       (in_pixel_y),
		.loc           (in_loc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_beat;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			kind_s1        <= in_kind;
			texel_index_s1 <= in_texel_index;
			pix_s1         <= in_pix;
			loc_s1         <= in_loc;
		end
	end

	// ---- stage 1: texel address row*width+column, bounded by loaded count ----
	always_comb begin
		ti_s1  = 15'({8'd0, loc_s1.dy} * {8'd0, cursor_width_q}) + {8'd0, loc_s1.dx};
		hit_s1 = loc_s1.in_rect && (ti_s1 < {2'b00, texel_count_q})
			&& (ti_s1 < 15'(STORE_DEPTH));
		// write a load beat exactly once, as it leaves stage 1
		load_we = valid_s1 && (kind_s1 == KIND_LOAD) && advance;
	end

	cob_sprite_mem u_sprite_mem (
		.clk   (clk),
		.we    (load_we),
		.waddr (texel_index_s1[STORE_AW-1:0]),
		.wdata (pix_s1),
		.re    (advance),
		.raddr (ti_s1[STORE_AW-1:0]),
		.rdata (texel_s2)
	);

	// Load beats drop out here; only pixels travel on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1 && (kind_s1 == KIND_PIXEL);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			hit_s2 <= hit_s1;
			pix_s2 <= pix_s1;
		end
	end

	// ---- stages 2 and 3: blend ----
	always_comb begin
		bin.valid = valid_s2;
		bin.hit   = hit_s2;
		bin.texel = texel_s2;
		bin.pixel = pix_s2;
	end

	cob_blend u_blend (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.bin     (bin),
		.valid   (blend_valid),
		.result  (blend_pix),
		.covered (blend_covered)
	);

	// ---- output register: hold the beat until the sink takes it ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= blend_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_pix_q <= blend_pix;
			covered_q <= blend_covered;
		end
	end

	assign m_tdata = out_pix_q;
	assign m_tuser = covered_q;

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the cursor overlay alpha blend block.
`timescale 1ns / 1ps

module testbench;
	import cob_pkg::*;

	localparam int HOLD_CYCLES = 400;     // long output hold-off
	localparam int DRAIN_QUIET = 8;       // ready cycles to let loads clear the pipe
	localparam int CYCLE_LIMIT = 400000;  // generous; the slowest clean run is far below
	localparam int RANDOM_ITEMS = 880;

	// Register image as seen by the block
	typedef struct {
		logic              en;
		logic signed [13:0] cx;
		logic signed [13:0] cy;
		logic [6:0]        cw;
		logic [6:0]        ch;
		logic [12:0]       tc;
		logic [13:0]       fw;
		logic [13:0]       fh;
	} overlay_cfg_t;

	typedef struct packed {
		pix_t pix;
		logic cov;
	} pixel_result_t;

	// One line of the directed stimulus; phase selects the register setting
	typedef struct {
		int            phase;
		kind_t         kind;
		logic [11:0]   idx;
		logic [12:0]   px;
		logic [12:0]   py;
		pix_t          pix;
		bit            typed;
		pixel_result_t want;
	} dir_row_t;

	typedef enum int {SINK_FREE, SINK_COIN, SINK_SPARSE, SINK_PERIODIC} sink_mode_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [71:0]           s_tdata = '0;
	logic [0:0]            s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [31:0]           m_tdata;
	logic [0:0]            m_tuser;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	// Predictor state: register copy, sprite store mirror, pending results
	overlay_cfg_t    cfg_now;
	logic [31:0]     sprite_mirror [STORE_DEPTH];
	bit              texel_loaded [STORE_DEPTH];
	pixel_result_t   expected_pixels [$];
	dir_row_t        directed_rows [$];
	overlay_cfg_t    directed_cfg [4];

	int  errors = 0;
	int  cycle_count = 0;
	int  burst_left = 0;
	int  n_pixels = 0;
	int  n_loads = 0;
	int  n_covered = 0;
	int  n_settings = 0;
	bit  hold_off_req = 1'b0;

	cursor_overlay_alpha_blend_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Watchdog: a hung handshake ends the run here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t ns: timeout with %0d results outstanding", $time,
				expected_pixels.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic overlay_cfg_t make_cfg(input bit en, input int cx, cy, cw, ch, tc,
			fw, fh);
		overlay_cfg_t c;
		c.en = en;
		c.cx = cx[13:0];
		c.cy = cy[13:0];
		c.cw = cw[6:0];
		c.ch = ch[6:0];
		c.tc = tc[12:0];
		c.fw = fw[13:0];
		c.fh = fh[13:0];
		return c;
	endfunction

	// Sprite store address a pixel reads under the current setting, or -1 where the
	// pixel is left alone (overlay off, outside cursor or frame, beyond the loaded count)
	function automatic int sprite_index(input logic [12:0] px, py);
		int cw, ch, fw, fh, cx, cy, pxi, pyi, dx, dy, ti, tc;
		cw = cfg_now.cw;
		ch = cfg_now.ch;
		fw = cfg_now.fw;
		fh = cfg_now.fh;
		cx = cfg_now.cx;
		cy = cfg_now.cy;
		tc = cfg_now.tc;
		pxi = px;
		pyi = py;
		// clamp oversized cursor and frame to the supported sides
		if (cw > CURSOR_MAX_SIDE_DEF) cw = CURSOR_MAX_SIDE_DEF;
		if (ch > CURSOR_MAX_SIDE_DEF) ch = CURSOR_MAX_SIDE_DEF;
		if (fw > FRAME_MAX_SIDE_DEF) fw = FRAME_MAX_SIDE_DEF;
		if (fh > FRAME_MAX_SIDE_DEF) fh = FRAME_MAX_SIDE_DEF;
		dx = pxi - cx;
		dy = pyi - cy;
		if (!cfg_now.en || dx < 0 || dy < 0 || dx >= cw || dy >= ch || pxi >= fw || pyi >= fh)
			return -1;
		ti = dy * cw + dx;
		if (ti >= tc || ti >= STORE_DEPTH)
			return -1;
		return ti;
	endfunction

	function automatic logic [7:0] mix_channel(input logic [7:0] s, d, a);
		int si, di, ai, v;
		si = s;
		di = d;
		ai = a;
		v = (si * ai + di * (int'(FULL_ALPHA) - ai)) / int'(FULL_ALPHA);
		return v[7:0];
	endfunction

	function automatic pixel_result_t blend_pixel(input logic [12:0] px, py, input pix_t p);
		pixel_result_t res;
		pix_t t;
		int ti;
		res.pix = p;
		res.cov = 1'b0;
		ti = sprite_index(px, py);
		if (ti >= 0) begin
			t = sprite_mirror[ti];
			// fourth byte of the texel is its alpha; the pixel keeps its own fourth byte
			if (t.fourth == FULL_ALPHA) begin
				res.pix.blue = t.blue;
				res.pix.green = t.green;
				res.pix.red = t.red;
				res.cov = 1'b1;
			end else if (t.fourth != 8'd0) begin
				res.pix.blue = mix_channel(t.blue, p.blue, t.fourth);
				res.pix.green = mix_channel(t.green, p.green, t.fourth);
				res.pix.red = mix_channel(t.red, p.red, t.fourth);
				res.cov = 1'b1;
			end
		end
		return res;
	endfunction

	function automatic pix_t random_texel();
		pix_t p;
		p = $urandom;
		// alpha leans towards the two ends, where the blend takes shortcuts
		case ($urandom_range(0, 3))
			0: p.fourth = 8'd0;
			1: p.fourth = FULL_ALPHA;
			default: ;
		endcase
		return p;
	endfunction

	function automatic void check_field(input string name, input logic [7:0] want, got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	task automatic add_row(input int ph, input kind_t k, input int idx, px, py,
			input logic [31:0] pix, input bit typed, input logic [31:0] want_pix,
			input logic want_cov);
		dir_row_t r;
		r.phase = ph;
		r.kind = k;
		r.idx = idx[11:0];
		r.px = px[12:0];
		r.py = py[12:0];
		r.pix = pix;
		r.typed = typed;
		r.want.pix = want_pix;
		r.want.cov = want_cov;
		directed_rows.push_back(r);
	endtask

	// Offer one beat, hold it until taken, then book the expectation and
	// apply the sender's burst/gap pattern
	task automatic offer_beat(input kind_t kind, input logic [11:0] idx,
			input logic [12:0] px, py, input pix_t p, input bit typed,
			input pixel_result_t want);
		s_tdata <= {2'b00, p.fourth, p.red, p.green, p.blue, py, px, idx};
		s_tuser <= kind;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (s_tready !== 1'b1);
		if (kind == KIND_LOAD) begin
			sprite_mirror[idx] = p;
			texel_loaded[idx] = 1'b1;
			n_loads++;
		end else begin
			expected_pixels.push_back(typed ? want : blend_pixel(px, py, p));
			n_pixels++;
		end
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(0, 6);
		end
	endtask

	// Drop valid, wait for every pending result, then count quiet ready cycles so that
	// trailing loads (which give no result) leave the pipe too
	task automatic wait_idle();
		int quiet;
		quiet = 0;
		s_tvalid <= 1'b0;
		while (expected_pixels.size() != 0 || quiet < DRAIN_QUIET) begin
			@(posedge clk);
			if (expected_pixels.size() == 0 && m_tready)
				quiet++;
		end
	endtask

	task automatic write_reg(input cfg_reg_t r, input logic [CFG_DATA_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_index <= r;
		cfg_wdata <= v;
		@(posedge clk);
	endtask

	task automatic set_config(input overlay_cfg_t c);
		write_reg(REG_OVERLAY_ENABLE, {13'd0, c.en});
		write_reg(REG_CURSOR_X, c.cx);
		write_reg(REG_CURSOR_Y, c.cy);
		write_reg(REG_CURSOR_WIDTH, {7'd0, c.cw});
		write_reg(REG_CURSOR_HEIGHT, {7'd0, c.ch});
		write_reg(REG_TEXEL_COUNT, {1'b0, c.tc});
		write_reg(REG_FRAME_WIDTH, c.fw);
		write_reg(REG_FRAME_HEIGHT, c.fh);
		cfg_we <= 1'b0;
		cfg_now = c;
		n_settings++;
	endtask

	// Result checker: every output beat must match the oldest pending expectation
	always @(posedge clk) begin : result_check
		pixel_result_t want;
		if (arst_n && m_tvalid === 1'b1 && m_tready) begin
			if (expected_pixels.size() == 0) begin
				$display("%0t ns: unexpected result beat, expected none, got data %h covered %b",
					$time, m_tdata, m_tuser);
				errors++;
			end else begin
				want = expected_pixels.pop_front();
				check_field("blue", want.pix.blue, m_tdata[7:0]);
				check_field("green", want.pix.green, m_tdata[15:8]);
				check_field("red", want.pix.red, m_tdata[23:16]);
				check_field("fourth", want.pix.fourth, m_tdata[31:24]);
				check_field("covered", {7'd0, want.cov}, {7'd0, m_tuser[0]});
				if (m_tuser[0] === 1'b1)
					n_covered++;
			end
		end
	end

	// Output side: stretches of free flow, coin-flip, sparse and periodic ready,
	// plus one long hold-off on request, counted here
	initial begin : sink
		sink_mode_t mode;
		int stretch_left;
		mode = SINK_FREE;
		stretch_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end else begin
				if (stretch_left == 0) begin
					mode = sink_mode_t'($urandom_range(0, 3));
					stretch_left = $urandom_range(16, 120);
				end
				stretch_left--;
				case (mode)
					SINK_FREE:   m_tready <= 1'b1;
					SINK_COIN:   m_tready <= 1'($urandom_range(0, 1));
					SINK_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
					default:     m_tready <= (cycle_count % 7 != 3);
				endcase
			end
		end
	end

	initial begin : stimulus
		dir_row_t      r;
		overlay_cfg_t  c;
		pixel_result_t none;
		pix_t          p;
		logic [11:0]   idx;
		logic [12:0]   px, py;
		int cur_phase, n_rand, phase_no, cwe, che, cxi, cyi, pxi, pyi, ti, fwi, fhi;
		int cwi, chi, tci;

		none = '0;

		// Directed: reset setting, then a small cursor at the origin, a clipped
		// cursor hanging off the top-left, and one parked in the far corner
		directed_cfg[1] = make_cfg(1, 0, 0, 4, 2, 8, 8192, 8192);
		directed_cfg[2] = make_cfg(1, -2, -1, 100, 127, 8191, 1, 16383);
		directed_cfg[3] = make_cfg(1, 8191, 8191, 64, 64, 1, 8192, 8192);

		// overlay off after reset: pixels pass untouched
		add_row(0, KIND_PIXEL, 0, 0, 0, 32'h4E38220C, 1, 32'h4E38220C, 0);
		add_row(0, KIND_PIXEL, 4095, 8191, 8191, 32'hFFFFFFFF, 1, 32'hFFFFFFFF, 0);
		add_row(0, KIND_PIXEL, 0, 1, 1, 32'h00000000, 1, 32'h00000000, 0);
		// texels: opaque, transparent, half, faintest, near-opaque, opaque black
		add_row(1, KIND_LOAD, 0, 0, 0, 32'hFF1E140A, 0, 0, 0);
		add_row(1, KIND_LOAD, 1, 0, 0, 32'h003C3228, 0, 0, 0);
		add_row(1, KIND_LOAD, 2, 0, 0, 32'h80FF00FF, 0, 0, 0);
		add_row(1, KIND_LOAD, 3, 0, 0, 32'h0100FF00, 0, 0, 0);
		add_row(1, KIND_LOAD, 4, 0, 0, 32'hFE123456, 0, 0, 0);
		add_row(1, KIND_LOAD, 5, 0, 0, 32'hFF000000, 0, 0, 0);
		add_row(1, KIND_PIXEL, 0, 0, 0, 32'h04030201, 1, 32'h041E140A, 1);
		add_row(1, KIND_PIXEL, 0, 1, 0, 32'hAABBCCDD, 1, 32'hAABBCCDD, 0);
		add_row(1, KIND_PIXEL, 0, 2, 0, 32'h0000FF00, 0, 0, 0);
		add_row(1, KIND_PIXEL, 0, 3, 0, 32'h7FFF00FF, 0, 0, 0);
		add_row(1, KIND_PIXEL, 0, 0, 1, 32'hFF00FF00, 0, 0, 0);
		add_row(1, KIND_PIXEL, 0, 1, 1, 32'h55667788, 1, 32'h55000000, 1);
		add_row(1, KIND_PIXEL, 0, 4, 0, 32'h11223344, 1, 32'h11223344, 0);
		add_row(1, KIND_PIXEL, 0, 0, 2, 32'h99887766, 1, 32'h99887766, 0);
		// oversized cursor clamped to 64 wide; one-column frame clips the rest
		add_row(2, KIND_LOAD, 66, 0, 0, 32'hFF090807, 0, 0, 0);
		add_row(2, KIND_PIXEL, 0, 0, 0, 32'h01020304, 1, 32'h01090807, 1);
		add_row(2, KIND_PIXEL, 0, 1, 0, 32'h10203040, 1, 32'h10203040, 0);
		// cursor origin at the last frame column and row
		add_row(3, KIND_PIXEL, 0, 8191, 8191, 32'hC3000000, 1, 32'hC31E140A, 1);
		add_row(3, KIND_PIXEL, 0, 8190, 8191, 32'h5A5A5A5A, 1, 32'h5A5A5A5A, 0);

		cfg_now = make_cfg(0, 0, 0, 0, 0, 0, 0, 0);
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		cur_phase = 0;
		foreach (directed_rows[i]) begin
			r = directed_rows[i];
			if (r.phase != cur_phase) begin
				wait_idle();
				set_config(directed_cfg[r.phase]);
				cur_phase = r.phase;
			end
			offer_beat(r.kind, r.idx, r.px, r.py, r.pix, r.typed, r.want);
		end

		// Random phases: a fresh register setting each, then a run of beats aimed
		// mostly at the cursor rectangle and its edges
		n_rand = 0;
		phase_no = 0;
		while (n_rand < RANDOM_ITEMS) begin
			wait_idle();
			case ($urandom_range(0, 9))
				0: cwi = $urandom_range(65, 127);
				1: cwi = 64;
				2: cwi = 1;
				3: cwi = 0;
				default: cwi = $urandom_range(1, 64);
			endcase
			case ($urandom_range(0, 9))
				0: chi = $urandom_range(65, 127);
				1: chi = 64;
				2: chi = 1;
				3: chi = 0;
				default: chi = $urandom_range(1, 64);
			endcase
			cwe = (cwi > CURSOR_MAX_SIDE_DEF) ? CURSOR_MAX_SIDE_DEF : cwi;
			che = (chi > CURSOR_MAX_SIDE_DEF) ? CURSOR_MAX_SIDE_DEF : chi;
			case ($urandom_range(0, 5))
				0: cxi = -256;
				1: cxi = int'($urandom_range(0, 255)) - 256;
				2: cxi = 8191 - int'($urandom_range(0, 70));
				3: cxi = 8191;
				default: cxi = $urandom_range(0, 300);
			endcase
			case ($urandom_range(0, 5))
				0: cyi = -256;
				1: cyi = int'($urandom_range(0, 255)) - 256;
				2: cyi = 8191 - int'($urandom_range(0, 70));
				3: cyi = 8191;
				default: cyi = $urandom_range(0, 300);
			endcase
			case ($urandom_range(0, 7))
				0: tci = 0;
				1: tci = 8191;
				2: tci = $urandom_range(0, 8191);
				3: tci = $urandom_range(0, cwe * che);
				default: tci = cwe * che;
			endcase
			case ($urandom_range(0, 5))
				0: fwi = 16383;
				1: fwi = $urandom_range(0, 16383);
				2: fwi = cxi + int'($urandom_range(0, cwe));
				default: fwi = 8192;
			endcase
			case ($urandom_range(0, 5))
				0: fhi = 16383;
				1: fhi = $urandom_range(0, 16383);
				2: fhi = cyi + int'($urandom_range(0, che));
				default: fhi = 8192;
			endcase
			if (fwi < 0) fwi = 0;
			if (fhi < 0) fhi = 0;
			c = make_cfg($urandom_range(0, 9) != 0, cxi, cyi, cwi, chi, tci, fwi, fhi);
			set_config(c);

			// Second phase: stall the output for a long stretch while beats keep coming
			if (phase_no == 1)
				hold_off_req = 1'b1;

			repeat ($urandom_range(40, 100)) begin
				if ($urandom_range(0, 3) == 0) begin
					// texel load, mostly inside the live sprite area
					if (cwe * che > 0 && $urandom_range(0, 4) != 0)
						idx = 12'($urandom_range(0, cwe * che - 1));
					else
						idx = 12'($urandom_range(0, STORE_DEPTH - 1));
					offer_beat(KIND_LOAD, idx, 13'($urandom), 13'($urandom), random_texel(),
						0, none);
				end else begin
					pxi = -1;
					pyi = -1;
					if (cwe > 0 && che > 0 && $urandom_range(0, 4) != 0) begin
						// one step past the far edges now and then
						pxi = cxi + int'($urandom_range(0, cwe));
						pyi = cyi + int'($urandom_range(0, che));
					end
					if (pxi < 0 || pxi > 8191) pxi = $urandom_range(0, 8191);
					if (pyi < 0 || pyi > 8191) pyi = $urandom_range(0, 8191);
					px = pxi[12:0];
					py = pyi[12:0];
					// never let a pixel read a texel that was not loaded: load it first
					ti = sprite_index(px, py);
					if (ti >= 0 && !texel_loaded[ti]) begin
						offer_beat(KIND_LOAD, ti[11:0], 13'($urandom), 13'($urandom),
							random_texel(), 0, none);
						n_rand++;
					end
					p = $urandom;
					offer_beat(KIND_PIXEL, 12'($urandom), px, py, p, 0, none);
				end
				n_rand++;
			end
			phase_no++;
		end

		wait_idle();
		$display("Covered %0d pixel beats (%0d blended) and %0d texel loads", n_pixels,
			n_covered, n_loads);
		$display("over %0d register settings, with bursty input and a stalling output",
			n_settings);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
